[rtl/pva_pkg.sv]
// Package: shared types and command codes for the voice allocator.
`timescale 1ns / 1ps
`default_nettype none
package pva_pkg;
    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_ON     = 2'd1,
        CMD_OFF    = 2'd2,
        CMD_CHOKE  = 2'd3
    } cmd_t;

    localparam logic CFG_ATTACK  = 1'b0;
    localparam logic CFG_RELEASE = 1'b1;

    typedef struct packed {
        logic [3:0] slot_index;
        logic       slot_given;
        logic       slot_stolen;
        logic [3:0] legato_index;
        logic       legato_found;
        logic [4:0] released_count;
        logic [4:0] active_count;
    } result_t;
endpackage
`default_nettype wire

[rtl/poly_voice_allocator_unit.sv]
// Top level: voice slot table with a slot-by-slot sequencer.
//
//  channel | direction | ports
//  s_      | in        | s_valid/s_ready, cmd, midi_channel, note_key, note_ident, velocity
//  m_      | out       | m_valid/m_ready, slot, legato and count fields
//  cfg_    | in        | cfg_valid/cfg_ready, cfg_index, cfg_data
//
// Every transaction runs the same steps, whatever the command: it is latched, every
// slot is scanned in turn through a single shared compare/update datapath, and then the
// chosen slot (for a note on) is written and the result posted.
// The slot table is in flip-flops cleared by reset; no clearing pass is needed.
// The result register holds while m_ready is low. A new transaction is taken while
// a result still waits; the write-back cycle holds until the result register is
// free or is being emptied.
`timescale 1ns / 1ps
`default_nettype none
module poly_voice_allocator_unit #(
    parameter int VOICE_SLOTS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_cmd,
    input  wire logic [3:0]  s_midi_channel,
    input  wire logic [6:0]  s_note_key,
    input  wire logic signed [15:0] s_note_ident,
    input  wire logic [6:0]  s_note_velocity,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_slot_index,
    output logic             m_slot_given,
    output logic             m_slot_stolen,
    output logic [3:0]       m_legato_index,
    output logic             m_legato_found,
    output logic [4:0]       m_released_count,
    output logic [4:0]       m_active_count,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);
    localparam int IW = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;
    localparam int CW = $clog2(VOICE_SLOTS + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FIN} state_t;

    state_t state_reg;
    logic [15:0] attack_reg, release_reg;
    logic [VOICE_SLOTS-1:0] act_reg, rel_reg;
    logic [3:0]  chan_mem [VOICE_SLOTS];
    logic [6:0]  key_mem  [VOICE_SLOTS];
    logic [15:0] id_mem   [VOICE_SLOTS];
    logic [31:0] age_mem  [VOICE_SLOTS];
    logic [15:0] env_mem  [VOICE_SLOTS];
    logic [31:0] age_cnt_reg;

    logic [1:0]  cmd_reg;
    logic [3:0]  ch_reg;
    logic [6:0]  key_reg, vel_reg;
    logic [15:0] id_reg;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] leg_reg, free_reg, steal_reg;
    logic leg_f_reg, free_f_reg;
    logic [CW-1:0] rcnt_reg, acnt_reg;
    pva_pkg::result_t res_reg;
    logic out_v_reg;

    // shared per-slot datapath, reads slot idx_reg
    logic a, r;
    logic [15:0] e;
    logic [16:0] up;
    logic is_on;
    assign a  = act_reg[idx_reg];
    assign r  = rel_reg[idx_reg];
    assign e  = env_mem[idx_reg];
    assign up = {1'b0, e} + {1'b0, attack_reg};
    assign is_on = (cmd_reg == pva_pkg::CMD_ON) && (vel_reg != 7'd0);

    logic match;
    assign match = id_reg[15] ? (chan_mem[idx_reg] == ch_reg && key_mem[idx_reg] == key_reg)
                              : (id_mem[idx_reg] == id_reg);

    logic last;
    assign last = (idx_reg == IW'(VOICE_SLOTS - 1));
    logic [IW-1:0] pick;
    assign pick = free_f_reg ? free_reg : steal_reg;

    // active count after the transaction: a note on into a free slot adds one
    logic [CW-1:0] acnt_fin;
    assign acnt_fin = acnt_reg + CW'(is_on && free_f_reg);

    logic [4:0] sat_r, sat_a;
    assign sat_r = (CW > 5 && rcnt_reg > CW'(31)) ? 5'd31 : 5'(rcnt_reg);
    assign sat_a = (CW > 5 && acnt_fin > CW'(31)) ? 5'd31 : 5'(acnt_fin);

    // write back only once the result register is free or being emptied
    logic post;
    assign post = (state_reg == ST_FIN) && (!out_v_reg || m_ready);

    pva_pkg::result_t res_next;
    always_comb begin
        res_next = '0;
        res_next.released_count = sat_r;
        res_next.active_count   = sat_a;
        if (is_on) begin
            res_next.slot_index   = 4'(pick);
            res_next.slot_given   = 1'b1;
            res_next.slot_stolen  = !free_f_reg;
            res_next.legato_index = leg_f_reg ? 4'(leg_reg) : 4'd0;
            res_next.legato_found = leg_f_reg;
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = out_v_reg;
    assign m_slot_index     = res_reg.slot_index;
    assign m_slot_given     = res_reg.slot_given;
    assign m_slot_stolen    = res_reg.slot_stolen;
    assign m_legato_index   = res_reg.legato_index;
    assign m_legato_found   = res_reg.legato_found;
    assign m_released_count = res_reg.released_count;
    assign m_active_count   = res_reg.active_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            attack_reg  <= 16'd170;
            release_reg <= 16'd55;
            act_reg     <= '0;
            rel_reg     <= '0;
            age_cnt_reg <= '0;
            out_v_reg   <= 1'b0;
            for (int i = 0; i < VOICE_SLOTS; i++) begin
                chan_mem[i] <= '0; key_mem[i] <= '0; id_mem[i] <= '0;
                age_mem[i] <= '0; env_mem[i] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                if (cfg_index == pva_pkg::CFG_ATTACK) attack_reg <= cfg_data;
                else release_reg <= cfg_data;
            end
            if (post) out_v_reg <= 1'b1;
            else if (out_v_reg && m_ready) out_v_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        cmd_reg <= s_cmd; ch_reg <= s_midi_channel; key_reg <= s_note_key;
                        id_reg <= s_note_ident; vel_reg <= s_note_velocity;
                        idx_reg <= '0; leg_f_reg <= 1'b0; free_f_reg <= 1'b0;
                        leg_reg <= '0; free_reg <= '0; steal_reg <= '0;
                        rcnt_reg <= '0; acnt_reg <= '0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (is_on) begin
                        // legato: first slot of greatest age stamp (newest) among held voices on this channel
                        if (a && !r && chan_mem[idx_reg] == ch_reg &&
                            (!leg_f_reg || age_mem[idx_reg] > age_mem[leg_reg])) begin
                            leg_reg <= idx_reg; leg_f_reg <= 1'b1;
                        end
                        if (!a && !free_f_reg) begin
                            free_reg <= idx_reg; free_f_reg <= 1'b1;
                        end
                        if (e < env_mem[steal_reg] || (e == env_mem[steal_reg] &&
                            age_mem[idx_reg] < age_mem[steal_reg]))
                            steal_reg <= idx_reg;
                        if (a) acnt_reg <= acnt_reg + CW'(1);
                    end else if (cmd_reg == pva_pkg::CMD_TICK) begin
                        if (a && r) begin
                            if (e > release_reg) begin
                                env_mem[idx_reg] <= e - release_reg;
                                acnt_reg <= acnt_reg + CW'(1);
                            end else begin
                                env_mem[idx_reg] <= '0;
                                act_reg[idx_reg] <= 1'b0;
                                rcnt_reg <= rcnt_reg + CW'(1);
                            end
                        end else if (a) begin
                            env_mem[idx_reg] <= up[16] ? 16'hFFFF : up[15:0];
                            acnt_reg <= acnt_reg + CW'(1);
                        end
                    end else begin
                        if (a) acnt_reg <= acnt_reg + CW'(1);
                        if (a && match) begin
                            rel_reg[idx_reg] <= 1'b1;
                            if (cmd_reg == pva_pkg::CMD_CHOKE) env_mem[idx_reg] <= '0;
                            rcnt_reg <= rcnt_reg + CW'(1);
                        end
                    end
                    if (last) state_reg <= ST_FIN;
                    else idx_reg <= idx_reg + IW'(1);
                end
                ST_FIN: begin
                    // write the chosen slot (note on) and post the result; hold while the old one waits
                    if (post) begin
                        if (is_on) begin
                            act_reg[pick] <= 1'b1; rel_reg[pick] <= 1'b0;
                            chan_mem[pick] <= ch_reg; key_mem[pick] <= key_reg;
                            id_mem[pick] <= id_reg;
                            age_mem[pick] <= age_cnt_reg + 32'd1;
                            env_mem[pick] <= '0;
                            age_cnt_reg <= age_cnt_reg + 32'd1;
                        end
                        res_reg   <= res_next;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("accepted while busy");
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_v_reg && !m_ready) |=> (out_v_reg && $stable(res_reg)))
        else $error("result dropped under stall");
    a_fin_posts: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN) |=> out_v_reg)
        else $error("result not posted");
    a_given_on: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_v_reg && res_reg.slot_stolen) |-> res_reg.slot_given)
        else $error("steal without slot");
`endif
endmodule
`default_nettype wire

[tb/tb_poly_voice_allocator_unit.sv]
// Testbench for the polyphonic voice allocator: directed table, random traffic, predictor check.
`timescale 1ns / 1ps
module tb_poly_voice_allocator_unit;

    localparam int SLOTS = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 60;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_cmd;
    logic [3:0]  s_midi_channel;
    logic [6:0]  s_note_key;
    logic signed [15:0] s_note_ident;
    logic [6:0]  s_note_velocity;
    logic        m_valid;
    logic        m_ready;
    logic [3:0]  m_slot_index;
    logic        m_slot_given;
    logic        m_slot_stolen;
    logic [3:0]  m_legato_index;
    logic        m_legato_found;
    logic [4:0]  m_released_count;
    logic [4:0]  m_active_count;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;

    poly_voice_allocator_unit #(.VOICE_SLOTS(SLOTS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_midi_channel(s_midi_channel), .s_note_key(s_note_key),
        .s_note_ident(s_note_ident), .s_note_velocity(s_note_velocity),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_slot_index(m_slot_index), .m_slot_given(m_slot_given),
        .m_slot_stolen(m_slot_stolen), .m_legato_index(m_legato_index),
        .m_legato_found(m_legato_found), .m_released_count(m_released_count),
        .m_active_count(m_active_count),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // One note event or tick as driven on the s_ channel.
    typedef struct {
        pva_pkg::cmd_t cmd;
        logic [3:0]  chan;
        logic [6:0]  key;
        logic [15:0] ident;
        logic [6:0]  vel;
    } voice_event_t;

    // Directed row: event plus an optional typed-in result.
    typedef struct {
        voice_event_t     ev;
        bit               has_known;
        pva_pkg::result_t known;
    } event_row_t;

    // Shadow copy of the voice table.
    logic        tbl_active    [SLOTS];
    logic        tbl_releasing [SLOTS];
    logic [3:0]  tbl_chan      [SLOTS];
    logic [6:0]  tbl_key       [SLOTS];
    logic [15:0] tbl_ident     [SLOTS];
    logic [31:0] tbl_age       [SLOTS];
    logic [16:0] tbl_env       [SLOTS];
    logic [6:0]  tbl_vel       [SLOTS];
    logic [31:0] age_clock;
    logic [15:0] attack_inc;
    logic [15:0] release_dec;

    pva_pkg::result_t pending_results[$];
    int          fail_count;
    int          idle_cycles = 0;
    int          send_idle_pct;
    int          recv_stall_pct;

    // Apply one event to the shadow table and return the result it produces.
    function automatic pva_pkg::result_t allocate_voice(voice_event_t ev);
        pva_pkg::result_t r;
        int      pick;
        int      leg;
        bit      found;
        int      released;
        int      active;
        bit      hit;
        r = '0;
        released = 0;
        if (ev.cmd == pva_pkg::CMD_TICK) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (tbl_active[i]) begin
                    if (tbl_releasing[i]) begin
                        tbl_env[i] = (tbl_env[i] > release_dec) ? tbl_env[i] - release_dec
                                                                : 17'd0;
                        if (tbl_env[i] == 0) begin
                            tbl_active[i] = 1'b0;
                            released++;
                        end
                    end else begin
                        tbl_env[i] = tbl_env[i] + attack_inc;
                        if (tbl_env[i] > 17'd65535) tbl_env[i] = 17'd65535;
                    end
                end
            end
        end else if (ev.cmd == pva_pkg::CMD_ON && ev.vel != 0) begin
            // Find the newest held voice on this channel before the slot is chosen.
            found = 0;
            leg = 0;
            for (int i = 0; i < SLOTS; i++) begin
                if (tbl_active[i] && !tbl_releasing[i] && tbl_chan[i] == ev.chan &&
                    (!found || tbl_age[i] > tbl_age[leg])) begin
                    leg = i;
                    found = 1;
                end
            end
            r.legato_found = found;
            r.legato_index = found ? leg[3:0] : 4'd0;
            pick = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (!tbl_active[i] && pick < 0) pick = i;
            end
            if (pick < 0) begin
                pick = 0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (tbl_env[i] < tbl_env[pick] ||
                        (tbl_env[i] == tbl_env[pick] && tbl_age[i] < tbl_age[pick]))
                        pick = i;
                end
                r.slot_stolen = 1'b1;
            end
            age_clock = age_clock + 32'd1;
            tbl_active[pick]    = 1'b1;
            tbl_releasing[pick] = 1'b0;
            tbl_chan[pick]      = ev.chan;
            tbl_key[pick]       = ev.key;
            tbl_ident[pick]     = ev.ident;
            tbl_vel[pick]       = ev.vel;
            tbl_age[pick]       = age_clock;
            tbl_env[pick]       = '0;
            r.slot_index = pick[3:0];
            r.slot_given = 1'b1;
        end else begin
            for (int i = 0; i < SLOTS; i++) begin
                if (tbl_active[i]) begin
                    if (!ev.ident[15]) hit = (tbl_ident[i] == ev.ident);
                    else hit = (tbl_chan[i] == ev.chan && tbl_key[i] == ev.key);
                    if (hit) begin
                        tbl_releasing[i] = 1'b1;
                        if (ev.cmd == pva_pkg::CMD_CHOKE) tbl_env[i] = '0;
                        released++;
                    end
                end
            end
        end
        active = 0;
        for (int i = 0; i < SLOTS; i++) active += int'(tbl_active[i]);
        r.released_count = (released > 31) ? 5'd31 : released[4:0];
        r.active_count   = (active > 31) ? 5'd31 : active[4:0];
        return r;
    endfunction

    // Watchdog: count cycles with no transaction on any channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog expired with %0d results outstanding",
                     $time, pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: stall at random, check each accepted transaction.
    always @(posedge aclk) begin
        pva_pkg::result_t got;
        pva_pkg::result_t exp;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_slot_index, m_slot_given, m_slot_stolen, m_legato_index,
                        m_legato_found, m_released_count, m_active_count};
                if (pending_results.size() == 0) begin
                    $display("%0t unexpected result, actual %p", $time, got);
                    fail_count++;
                end else begin
                    exp = pending_results.pop_front();
                    if (got !== exp) begin
                        $display("%0t result mismatch: expected %p actual %p", $time, exp, got);
                        fail_count++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Drive one transaction; hold valid until it is taken.
    task automatic send_event(voice_event_t ev, bit has_known, pva_pkg::result_t known);
        pva_pkg::result_t r;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_cmd           <= ev.cmd;
        s_midi_channel  <= ev.chan;
        s_note_key      <= ev.key;
        s_note_ident    <= ev.ident;
        s_note_velocity <= ev.vel;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        r = allocate_voice(ev);
        if (has_known && r !== known) begin
            $display("%0t directed row disagrees: expected %p predicted %p", $time, known, r);
            fail_count++;
        end
        pending_results.push_back(has_known ? known : r);
    endtask

    // Drop valid, wait until every result is back, then let the sequencer settle.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(logic idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        if (idx == pva_pkg::CFG_ATTACK) attack_inc = value;
        else release_dec = value;
    endtask

    function automatic voice_event_t make_event(pva_pkg::cmd_t c, int ch, int k, int id,
                                                int v);
        voice_event_t ev;
        ev.cmd = c; ev.chan = 4'(ch); ev.key = 7'(k); ev.ident = 16'(id); ev.vel = 7'(v);
        return ev;
    endfunction

    function automatic pva_pkg::result_t make_result(int si, int g, int st, int li, int lf,
                                                     int rc, int ac);
        pva_pkg::result_t r;
        r = '{si[3:0], g[0], st[0], li[3:0], lf[0], rc[4:0], ac[4:0]};
        return r;
    endfunction

    // Random event: mostly well-formed note traffic on few channels and keys.
    function automatic voice_event_t random_event();
        voice_event_t ev;
        int sel;
        sel = int'($urandom_range(99));
        ev.chan  = 4'(($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(2));
        ev.key   = 7'(($urandom_range(3) == 0) ? $urandom_range(127) : 60 + $urandom_range(5));
        ev.vel   = ($urandom_range(9) == 0) ? 7'd0 : 7'($urandom_range(127));
        if ($urandom_range(1) != 0) ev.ident = 16'hFFFF;
        else if ($urandom_range(3) == 0) ev.ident = 16'($urandom_range(65535));
        else ev.ident = 16'($urandom_range(7));
        if (sel < 35)      ev.cmd = pva_pkg::CMD_TICK;
        else if (sel < 70) ev.cmd = pva_pkg::CMD_ON;
        else if (sel < 90) ev.cmd = pva_pkg::CMD_OFF;
        else               ev.cmd = pva_pkg::CMD_CHOKE;
        return ev;
    endfunction

    initial begin
        event_row_t       rows[$];
        event_row_t       row;
        pva_pkg::result_t none;
        logic [15:0]      attack_set[4];
        logic [15:0]      release_set[4];

        none = '0;
        fail_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_cmd = pva_pkg::CMD_TICK;
        s_midi_channel = '0;
        s_note_key = '0;
        s_note_ident = '0;
        s_note_velocity = '0;
        cfg_valid = 1'b0;
        cfg_index = pva_pkg::CFG_ATTACK;
        cfg_data = '0;
        age_clock = '0;
        attack_inc = 16'd170;
        release_dec = 16'd55;
        for (int i = 0; i < SLOTS; i++) begin
            tbl_active[i] = 0; tbl_releasing[i] = 0; tbl_chan[i] = 0; tbl_key[i] = 0;
            tbl_ident[i] = 0; tbl_age[i] = 0; tbl_env[i] = 0; tbl_vel[i] = 0;
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table: reset state, extremes, steal path, repeated release, velocity zero.
        rows.push_back('{make_event(pva_pkg::CMD_TICK, 0, 0, 0, 0), 1,
                         make_result(0,0,0,0,0,0,0)});
        rows.push_back('{make_event(pva_pkg::CMD_OFF, 15, 127, 16'hFFFF, 127), 1, none});
        rows.push_back('{make_event(pva_pkg::CMD_ON, 15, 127, 16'h7FFF, 127), 1,
                         make_result(0,1,0,0,0,0,1)});
        rows.push_back('{make_event(pva_pkg::CMD_ON, 15, 0, 16'h8000, 1), 1,
                         make_result(1,1,0,0,1,0,2)});
        rows.push_back('{make_event(pva_pkg::CMD_ON, 3, 5, 1, 0), 0, none});
        rows.push_back('{make_event(pva_pkg::CMD_OFF, 0, 0, 16'h7FFF, 0), 0, none});
        rows.push_back('{make_event(pva_pkg::CMD_OFF, 0, 0, 16'h7FFF, 0), 0, none});
        rows.push_back('{make_event(pva_pkg::CMD_CHOKE, 15, 0, 16'hFFFF, 0), 0, none});
        rows.push_back('{make_event(pva_pkg::CMD_TICK, 0, 0, 0, 0), 0, none});
        for (int i = 0; i < 17; i++)
            rows.push_back('{make_event(pva_pkg::CMD_ON, i % 3, i, i, 64), 0, none});
        rows.push_back('{make_event(pva_pkg::CMD_TICK, 0, 0, 0, 0), 0, none});
        for (int i = 0; i < rows.size(); i++) begin
            row = rows[i];
            send_event(row.ev, row.has_known, row.known);
        end
        wait_drained();

        // Random phases, one register setting and idling mix each, extremes included.
        attack_set  = '{16'd1, 16'd65535, 16'd0, 16'd4000};
        release_set = '{16'd65535, 16'd1, 16'd0, 16'd700};
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                3: begin send_idle_pct = 29; recv_stall_pct = 29; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            write_register(pva_pkg::CFG_ATTACK,
                           (phase < 4) ? attack_set[phase] : 16'($urandom_range(65535)));
            write_register(pva_pkg::CFG_RELEASE,
                           (phase < 4) ? release_set[phase] : 16'($urandom_range(65535)));
            for (int n = 0; n < 170; n++)
                send_event(random_event(), 0, none);
            wait_drained();
        end

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

[filelist.f]
rtl/pva_pkg.sv
rtl/poly_voice_allocator_unit.sv
tb/tb_poly_voice_allocator_unit.sv
